[rtl/isqn_pkg.sv]
`default_nettype none
package isqn_pkg;

  localparam int unsigned RefineStepsDef = 6;
  localparam int unsigned Width          = 32;
  localparam int unsigned DivBits        = 2;
  localparam int unsigned DivStages      = Width / DivBits;

  localparam logic [Width-1:0] BigThreshold = 32'd1048576;
  localparam logic [Width-1:0] BigSeed      = 32'd8192;
  localparam logic [Width-1:0] SmallSeed    = 32'd128;

  // one radicand in flight with its current guess
  typedef struct packed {
    logic             pos;
    logic [Width-1:0] value;
    logic [Width-1:0] guess;
  } item_t;

  // restoring divider state: value / guess
  typedef struct packed {
    item_t            item;
    logic [Width-1:0] rem;
    logic [Width-1:0] quo;
    logic [Width-1:0] dvd;
  } div_t;

endpackage
`default_nettype wire

[rtl/isqn_div_step.sv]
`default_nettype none
module isqn_div_step (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic         valid_i,
  input  wire isqn_pkg::div_t d_i,
  output logic              valid_o,
  output isqn_pkg::div_t    d_o
);
  import isqn_pkg::*;

  div_t             d_d, d_q;
  logic             valid_q;
  logic [Width-1:0] divisor;
  logic [Width:0]   wide;

  assign divisor = (d_i.item.guess == '0) ? Width'(1) : d_i.item.guess;

  // retire DivBits quotient bits per stage
  always_comb begin
    d_d  = d_i;
    wide = '0;
    for (int b = 0; b < DivBits; b++) begin
      wide    = {d_d.rem, d_d.dvd[Width-1]};
      d_d.dvd = {d_d.dvd[Width-2:0], 1'b0};
      if (wide >= {1'b0, divisor}) begin
        wide    = wide - {1'b0, divisor};
        d_d.quo = {d_d.quo[Width-2:0], 1'b1};
      end else begin
        d_d.quo = {d_d.quo[Width-2:0], 1'b0};
      end
      d_d.rem = wide[Width-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;
endmodule
`default_nettype wire

[rtl/isqn_refine.sv]
`default_nettype none
module isqn_refine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire isqn_pkg::item_t item_i,
  output logic               valid_o,
  output isqn_pkg::item_t    item_o
);
  import isqn_pkg::*;

  div_t           chain [DivStages+1];
  logic           vchain [DivStages+1];
  item_t          item_d, item_q;
  logic           valid_q;
  logic [Width:0] sum;

  assign chain[0]  = '{item: item_i, rem: '0, quo: '0, dvd: item_i.value};
  assign vchain[0] = valid_i;

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    isqn_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (vchain[s]),
      .d_i     (chain[s]),
      .valid_o (vchain[s+1]),
      .d_o     (chain[s+1])
    );
  end

  // average guess and quotient
  always_comb begin
    item_d       = chain[DivStages].item;
    sum          = {1'b0, item_d.guess} + {1'b0, chain[DivStages].quo};
    item_d.guess = sum[Width:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= vchain[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule
`default_nettype wire

[rtl/integer_sqrt_newton.sv]
`default_nettype none
// Integer square root by a fixed number of Babylonian refinements. Each
// transaction on the slave side carries one signed 32-bit radicand; one
// transaction per radicand leaves the master side with a 16-bit root. A
// radicand of zero or below yields 0. The first guess is 8192 above 1048576
// and 128 otherwise, followed by REFINE_STEPS steps of
// guess = (guess + radicand / guess) / 2; small radicands may not converge,
// and the low 16 bits of the final guess are returned as they stand.
// The pipeline takes one radicand every cycle while it is not held. It has
// a seed stage, per refinement a 16-stage restoring divider retiring two
// quotient bits per stage plus an averaging stage, and the output register.
// The whole pipeline holds when the output register is full and not taken.
module integer_sqrt_newton #(
  parameter int unsigned REFINE_STEPS = isqn_pkg::RefineStepsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // [31:0] radicand
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o   // [15:0] root
);
  import isqn_pkg::*;

  logic  en;
  item_t seed_d, seed_q;
  logic  seed_valid_q;
  item_t items  [REFINE_STEPS+1];
  logic  valids [REFINE_STEPS+1];
  logic  out_valid_q;
  logic [15:0] root_d, root_q;

  // advance everything unless a finished root is still waiting
  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // pick the starting guess
  always_comb begin
    seed_d.value = s_axis_tdata_i;
    seed_d.pos   = !s_axis_tdata_i[Width-1] && (s_axis_tdata_i != '0);
    seed_d.guess = (s_axis_tdata_i > BigThreshold) ? BigSeed : SmallSeed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_valid_q <= 1'b0;
    end else if (en) begin
      seed_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      seed_q <= seed_d;
    end
  end

  assign items[0]  = seed_q;
  assign valids[0] = seed_valid_q;

  for (genvar r = 0; r < REFINE_STEPS; r++) begin : g_refine
    isqn_refine u_refine (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valids[r]),
      .item_i  (items[r]),
      .valid_o (valids[r+1]),
      .item_o  (items[r+1])
    );
  end

  // drop to zero for non-positive radicands, keep the low 16 bits
  assign root_d = items[REFINE_STEPS].pos ? items[REFINE_STEPS].guess[15:0] : 16'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valids[REFINE_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      root_q <= root_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = root_q;
endmodule
`default_nettype wire
